// File: src/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int unsigned FIELD_WIDTH       = 32;
  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] base_value;
    logic [FIELD_WIDTH-1:0] exponent;
    logic [FIELD_WIDTH-1:0] modulus;
  } mexp_in_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] power_result;
    logic                   modulus_error;
  } mexp_out_t;

  // control from the sequencer to the modular multiplier
  typedef struct packed {
    logic start;
  } mexp_mm_ctrl_t;

  // status back from the modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mm_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_BIT,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } mexp_state_t;

endpackage

// File: src/mexp_mmul.sv
`timescale 1ns / 1ps

// Bit-serial modular multiplier: (x * y) mod m, y scanned MSB first,
// one bit per cycle. Needs x < m, or x = 1 with m = 1.
module mexp_mmul #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mexp_pkg::mexp_mm_ctrl_t      ctrl,
  input  logic [OPERAND_WIDTH-1:0]     op_x,
  input  logic [OPERAND_WIDTH-1:0]     op_y,
  input  logic [OPERAND_WIDTH-1:0]     op_m,
  output mexp_pkg::mexp_mm_stat_t      stat,
  output logic [OPERAND_WIDTH-1:0]     product
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     x_r;
  logic [W-1:0]     y_r;
  logic [W-1:0]     m_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [W:0] dbl, dbl_red, sum, addend;

  always_comb begin
    dbl     = {1'b0, acc_r} + {1'b0, acc_r};
    dbl_red = (dbl >= {1'b0, m_r}) ? (dbl - {1'b0, m_r}) : dbl;
    addend  = y_r[W-1] ? {1'b0, x_r} : '0;
    sum     = dbl_red + addend;
    acc_nxt = (sum >= {1'b0, m_r}) ? W'(sum - {1'b0, m_r}) : sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc_r <= '0;
      x_r   <= op_x;
      y_r   <= op_y;
      m_r   <= op_m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

// File: src/modular_exponentiation.sv
`timescale 1ns / 1ps

// Channel | Ports                         | Carries
// in      | in_valid, in_ready, in_data   | base_value, exponent, modulus
// out     | out_valid, out_ready, out_data| power_result, modulus_error
//
// One request at a time. Every modular product is a bit-serial multiply in the
// shared multiplier, which sets the rate. A request runs a base reduction, then per
// exponent bit up to the highest set one a square, preceded by a multiply when the
// bit is set. A zero modulus skips the multiplier and goes straight to the finish
// step. Reset is synchronous, active low.
// A held result does not block the next request; only the finish step waits on out_ready.
module modular_exponentiation #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mexp_pkg::mexp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mexp_pkg::mexp_out_t out_data
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned FW = mexp_pkg::FIELD_WIDTH;

  mexp_pkg::mexp_state_t   state_r, state_nxt;
  mexp_pkg::mexp_mm_ctrl_t mm_ctrl;
  mexp_pkg::mexp_mm_stat_t mm_stat;

  logic [W-1:0] mod_r, exp_r, result_r, square_r;
  logic         err_r;
  logic [W-1:0] op_x, op_y, op_m, product;
  logic         out_valid_r;
  mexp_pkg::mexp_out_t out_data_r;

  logic [W+FW-1:0] base_wide, exp_wide, mod_wide, res_wide;
  logic [W-1:0]    base_ext, exp_ext, mod_ext;
  logic            accept, load_out;

  // take the low W bits of each field, zero-filled when W exceeds the field
  assign base_wide = {{W{1'b0}}, in_data.base_value};
  assign exp_wide  = {{W{1'b0}}, in_data.exponent};
  assign mod_wide  = {{W{1'b0}}, in_data.modulus};
  assign base_ext  = base_wide[W-1:0];
  assign exp_ext   = exp_wide[W-1:0];
  assign mod_ext   = mod_wide[W-1:0];
  assign res_wide  = {{FW{1'b0}}, result_r};

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (mod_ext == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_RED;
        end
      end
      mexp_pkg::ST_RED: begin
        if (mm_stat.done) state_nxt = mexp_pkg::ST_BIT;
      end
      mexp_pkg::ST_BIT: begin
        priority if (exp_r == '0) state_nxt = mexp_pkg::ST_DONE;
        else if (exp_r[0])        state_nxt = mexp_pkg::ST_MUL;
        else                      state_nxt = mexp_pkg::ST_SQR;
      end
      mexp_pkg::ST_MUL: begin
        if (mm_stat.done) state_nxt = mexp_pkg::ST_SQR;
      end
      mexp_pkg::ST_SQR: begin
        if (mm_stat.done) state_nxt = mexp_pkg::ST_BIT;
      end
      mexp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = mexp_pkg::ST_IDLE;
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready      = 1'b0;
    mm_ctrl.start = 1'b0;
    load_out      = 1'b0;
    op_x          = square_r;
    op_y          = square_r;
    op_m          = mod_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        // base mod m is 1 * base mod m through the multiplier
        mm_ctrl.start = in_valid && (mod_ext != '0);
        op_x          = W'(1);
        op_y          = base_ext;
        op_m          = mod_ext;
      end
      mexp_pkg::ST_BIT: begin
        mm_ctrl.start = (exp_r != '0);
        if (exp_r[0]) op_x = result_r;
        op_y          = square_r;
      end
      mexp_pkg::ST_MUL: begin
        mm_ctrl.start = mm_stat.done;
      end
      mexp_pkg::ST_DONE: begin
        load_out = !out_valid_r || out_ready;
      end
      mexp_pkg::ST_RED, mexp_pkg::ST_SQR: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mexp_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mod_r    <= mod_ext;
      exp_r    <= exp_ext;
      err_r    <= (mod_ext == '0);
      result_r <= '0;
    end else if (mm_stat.done) begin
      unique case (state_r)
        mexp_pkg::ST_RED: begin
          square_r <= product;
          result_r <= (mod_r == W'(1)) ? '0 : W'(1);
        end
        mexp_pkg::ST_MUL: result_r <= product;
        mexp_pkg::ST_SQR: begin
          square_r <= product;
          exp_r    <= exp_r >> 1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.power_result  <= res_wide[FW-1:0];
      out_data_r.modulus_error <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mexp_mmul #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_mmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mm_ctrl),
    .op_x   (op_x),
    .op_y   (op_y),
    .op_m   (op_m),
    .stat   (mm_stat),
    .product(product)
  );

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_ctrl.start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.modulus_error) |-> (out_data_r.power_result == '0))
    else $error("error result carries nonzero power");

  a_zero_mod_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (mod_ext == '0)) |=> (state_r == mexp_pkg::ST_DONE))
    else $error("zero modulus did not finish at once");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |-> (state_r == mexp_pkg::ST_RED || state_r == mexp_pkg::ST_MUL ||
                      state_r == mexp_pkg::ST_SQR))
    else $error("multiplier finished outside a wait state");

endmodule
